FILE: hw/rtl/drns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drns_pkg: shared types and constants for the directional neighbor select
// Request and response payloads, focus and running-best records, codes.
// ----------------------------------------------------------------------------
package drns_pkg;

	localparam int EDGE_W         = 32;                     // Q16.16 edge coordinate
	localparam int CTR_W          = EDGE_W + 1;             // doubled center (edge sum)
	localparam int GAP_W          = EDGE_W + 1;             // clamped edge gap
	localparam int OFF_W          = CTR_W + 1;              // center offset magnitude
	localparam int MAX_CANDIDATES = 256;
	localparam int IDX_W          = $clog2(MAX_CANDIDATES);
	localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
	localparam int BEST_W         = 9;
	localparam int EPS_MUL_W      = 7;
	localparam int EPS_MUL        = 107;
	localparam int EPS_SHIFT      = 20;
	localparam int PROD_W         = EDGE_W + EPS_MUL_W;
	localparam int TOL_W          = PROD_W - EPS_SHIFT;

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} drns_dir_t;

	typedef enum logic {
		ACT_BEGIN = 1'b0,
		ACT_CAND  = 1'b1
	} drns_action_t;

	typedef struct packed {
		drns_action_t             action;
		drns_dir_t                direction;
		logic                     require_overlap;
		logic signed [EDGE_W-1:0] left;
		logic signed [EDGE_W-1:0] top;
		logic signed [EDGE_W-1:0] right;
		logic signed [EDGE_W-1:0] bottom;
		logic                     last;
	} drns_req_t;

	typedef struct packed {
		logic signed [BEST_W-1:0] best_index;
		logic                     found;
		logic                     overflow;
	} drns_rsp_t;

	typedef struct packed {
		logic signed [EDGE_W-1:0] l;
		logic signed [EDGE_W-1:0] t;
		logic signed [EDGE_W-1:0] r;
		logic signed [EDGE_W-1:0] b;
		logic signed [CTR_W-1:0]  cx;
		logic signed [CTR_W-1:0]  cy;
		logic [TOL_W-1:0]         tol;
		drns_dir_t                dir;
		logic                     req;
	} drns_focus_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		logic             ov;
		logic [GAP_W-1:0] gap;
		logic [OFF_W-1:0] perp;
		logic [OFF_W-1:0] axis;
	} drns_best_t;

	typedef struct packed {
		logic             take;
		logic             ov;
		logic [GAP_W-1:0] gap;
		logic [OFF_W-1:0] perp;
		logic [OFF_W-1:0] axis;
	} drns_rank_t;

	localparam drns_focus_t FOCUS_RESET = '{
		l: '0, t: '0, r: '0, b: '0, cx: '0, cy: '0, tol: '0, dir: DIR_LEFT, req: 1'b0
	};

	localparam drns_best_t BEST_CLEAR = '{
		found: 1'b0, idx: '0, ov: 1'b0, gap: '1, perp: '1, axis: '1
	};

endpackage

FILE: hw/rtl/drns_rank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drns_rank: candidate filter and ranking against the running best
// Computes keys of one candidate and whether it replaces the current best.
// ----------------------------------------------------------------------------
module drns_rank (
	input  drns_pkg::drns_focus_t                 focus,
	input  drns_pkg::drns_best_t                  best,
	input  logic signed [drns_pkg::EDGE_W-1:0]    left,
	input  logic signed [drns_pkg::EDGE_W-1:0]    top,
	input  logic signed [drns_pkg::EDGE_W-1:0]    right,
	input  logic signed [drns_pkg::EDGE_W-1:0]    bottom,
	output drns_pkg::drns_rank_t                  rank
);
	import drns_pkg::*;

	logic signed [CTR_W-1:0]  cx, cy;
	logic signed [OFF_W-1:0]  dx, dy;
	logic [OFF_W-1:0]         adx, ady;
	logic                     horiz, fwd, ahead, concentric, ov, keep, better;
	logic signed [EDGE_W-1:0] ga, gb;
	logic signed [EDGE_W:0]   gap_raw;
	logic [GAP_W-1:0]         gap;
	logic [OFF_W-1:0]         perp, axis;
	logic [TOL_W:0]           eps2;
	logic                     gap_lt, gap_le, perp_lt, perp_le, axis_lt;

	always_comb begin
		cx = {left[EDGE_W-1], left} + {right[EDGE_W-1], right};
		cy = {top[EDGE_W-1], top} + {bottom[EDGE_W-1], bottom};
		dx = {cx[CTR_W-1], cx} - {focus.cx[CTR_W-1], focus.cx};
		dy = {cy[CTR_W-1], cy} - {focus.cy[CTR_W-1], focus.cy};
		adx = dx[OFF_W-1] ? (~dx + 1'b1) : dx;
		ady = dy[OFF_W-1] ? (~dy + 1'b1) : dy;

		horiz = (focus.dir == DIR_LEFT) || (focus.dir == DIR_RIGHT);
		fwd   = (focus.dir == DIR_RIGHT) || (focus.dir == DIR_DOWN);
		concentric = (cx == focus.cx) && (cy == focus.cy);

		if (horiz) begin
			ahead = fwd ? (cx > focus.cx) : (cx < focus.cx);
			ga    = fwd ? left : focus.l;
			gb    = fwd ? focus.r : right;
			// positive vertical overlap: min(bottoms) above max(tops)
			ov    = (focus.b > focus.t) && (focus.b > top) &&
				(bottom > focus.t) && (bottom > top);
			perp  = ady;
			axis  = adx;
		end else begin
			ahead = fwd ? (cy > focus.cy) : (cy < focus.cy);
			ga    = fwd ? top : focus.t;
			gb    = fwd ? focus.b : bottom;
			ov    = (focus.r > focus.l) && (focus.r > left) &&
				(right > focus.l) && (right > left);
			perp  = adx;
			axis  = ady;
		end

		gap_raw = {ga[EDGE_W-1], ga} - {gb[EDGE_W-1], gb};
		gap     = gap_raw[EDGE_W] ? '0 : {1'b0, gap_raw[EDGE_W-1:0]};
		eps2    = {focus.tol, 1'b0};

		// tolerance compares, widened by one bit so nothing wraps
		gap_lt  = ({1'b0, gap} + (GAP_W+1)'(focus.tol)) < {1'b0, best.gap};
		gap_le  = {1'b0, gap} <= ({1'b0, best.gap} + (GAP_W+1)'(focus.tol));
		perp_lt = ({1'b0, perp} + (OFF_W+1)'(eps2)) < {1'b0, best.perp};
		perp_le = {1'b0, perp} <= ({1'b0, best.perp} + (OFF_W+1)'(eps2));
		axis_lt = ({1'b0, axis} + (OFF_W+1)'(eps2)) < {1'b0, best.axis};

		keep   = !concentric && ahead && !(focus.req && !ov);
		better = (ov != best.ov) ? ov :
			(gap_lt || (gap_le && (perp_lt || (perp_le && axis_lt))));

		rank.take = keep && better;
		rank.ov   = ov;
		rank.gap  = gap;
		rank.perp = perp;
		rank.axis = axis;
	end

endmodule

FILE: hw/rtl/directional_rect_neighbor_select_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directional_rect_neighbor_select_unit: nearest rectangle in a direction
// Streams a focus rectangle and candidates, returns the best candidate index.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_data): a begin request sets
//   the focus rectangle, direction and overlap flag; each candidate request
//   is numbered from 0 and ranked against the running best. A request with
//   last set ends the list and produces one response.
//   Response channel (rsp_valid / rsp_stall / rsp_data): best_index (-1 when
//   nothing qualified), found and overflow.
//   Throughput: one request per cycle unless a last request is held. Each
//   request is registered, then ranked and folded into the running best;
//   the loop through the ranking compare and the best register sets this.
//   Response: rsp_valid is registered and rises at the edge that folds the
//   last request into the running best; a response still held by rsp_stall
//   delays that fold.
//   Stall: a waiting response holds only a later request that carries last,
//   and the requests queued behind it; others flow into the running best.
//   Reset: focus is the zero rectangle, direction left, no overlap demand,
//   the running best and candidate count are cleared, no response pending.
// ----------------------------------------------------------------------------
module directional_rect_neighbor_select_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  drns_pkg::drns_req_t req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output drns_pkg::drns_rsp_t rsp_data
);
	import drns_pkg::*;

	// input register
	logic        req_valid_s1;
	drns_req_t   req_s1;
	logic        adv;

	// query state and running best
	drns_focus_t focus_q, focus_d;
	drns_best_t  best_q, best_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic        ovf_q, ovf_d;

	// response register
	logic        rsp_valid_q;
	drns_rsp_t   rsp_q, rsp_d;
	logic        emit;

	drns_rank_t  rank;

	// tolerance of a new focus
	logic signed [EDGE_W:0]   span_w, span_h, span_mx;
	logic [EDGE_W-1:0]        span_m;
	logic [PROD_W-1:0]        prod;

	drns_rank u_rank (
		.focus  (focus_q),
		.best   (best_q),
		.left   (req_s1.left),
		.top    (req_s1.top),
		.right  (req_s1.right),
		.bottom (req_s1.bottom),
		.rank   (rank)
	);

	// Hold the registered request only when it carries last and the previous
	// response is still waiting to be taken.
	assign adv       = req_valid_s1 && !(req_s1.last && rsp_valid_q && rsp_stall);
	assign req_stall = req_valid_s1 && !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		span_w  = {req_s1.right[EDGE_W-1], req_s1.right} - {req_s1.left[EDGE_W-1], req_s1.left};
		span_h  = {req_s1.bottom[EDGE_W-1], req_s1.bottom} - {req_s1.top[EDGE_W-1], req_s1.top};
		span_mx = (span_w > span_h) ? span_w : span_h;
		// an empty or inverted focus counts as one LSB
		span_m  = (!span_mx[EDGE_W] && (span_mx != '0)) ? span_mx[EDGE_W-1:0] : EDGE_W'(1);
		prod    = PROD_W'(span_m) * PROD_W'(EPS_MUL);
	end

	always_comb begin
		focus_d = focus_q;
		best_d  = best_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		rsp_d   = rsp_q;
		emit    = 1'b0;
		if (adv) begin
			if (req_s1.action == ACT_BEGIN) begin
				// load the new focus and restart the list
				focus_d.l   = req_s1.left;
				focus_d.t   = req_s1.top;
				focus_d.r   = req_s1.right;
				focus_d.b   = req_s1.bottom;
				focus_d.cx  = {req_s1.left[EDGE_W-1], req_s1.left} +
					{req_s1.right[EDGE_W-1], req_s1.right};
				focus_d.cy  = {req_s1.top[EDGE_W-1], req_s1.top} +
					{req_s1.bottom[EDGE_W-1], req_s1.bottom};
				focus_d.tol = prod[PROD_W-1:EPS_SHIFT];
				focus_d.dir = req_s1.direction;
				focus_d.req = req_s1.require_overlap;
				best_d      = BEST_CLEAR;
				cnt_d       = '0;
				ovf_d       = 1'b0;
			end else if (cnt_q == CNT_W'(MAX_CANDIDATES)) begin
				// drop candidates past capacity, remember that it happened
				ovf_d = 1'b1;
			end else begin
				if (rank.take) begin
					best_d.found = 1'b1;
					best_d.idx   = cnt_q[IDX_W-1:0];
					best_d.ov    = rank.ov;
					best_d.gap   = rank.gap;
					best_d.perp  = rank.perp;
					best_d.axis  = rank.axis;
				end
				cnt_d = cnt_q + 1'b1;
			end
			if (req_s1.last) begin
				// report the list, then clear for the next one against same focus
				emit             = 1'b1;
				rsp_d.best_index = best_d.found ? BEST_W'(best_d.idx) : '1;
				rsp_d.found      = best_d.found;
				rsp_d.overflow   = ovf_d;
				best_d           = BEST_CLEAR;
				cnt_d            = '0;
				ovf_d            = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
			focus_q      <= FOCUS_RESET;
			best_q       <= BEST_CLEAR;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				req_valid_s1 <= 1'b1;
			end else if (adv) begin
				req_valid_s1 <= 1'b0;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			focus_q <= focus_d;
			best_q  <= best_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	// found and a non-negative index always travel together
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.found == !rsp_q.best_index[BEST_W-1]))
		else $error("found disagrees with best_index sign");

	// the candidate count saturates at capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_CANDIDATES))
		else $error("candidate count beyond capacity");

	// a completed list leaves a cleared running best
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_s1.last) |=> (cnt_q == '0) && !best_q.found && !ovf_q && rsp_valid_q)
		else $error("running best not cleared after a response");

	// back-pressure only comes from a pending response blocking a last request
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (req_valid_s1 && req_s1.last && rsp_valid_q))
		else $error("request stalled without a waiting response");

endmodule
